@@ rtl/tsoa_pkg.sv @@
// Package: shared widths, command and status codes, a control struct for the two-stack unit.
`timescale 1ns / 1ps
`default_nettype none
package tsoa_pkg;

    localparam int WORD_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH_L = 3'd0;
    localparam t_cmd CMD_PUSH_R = 3'd1;
    localparam t_cmd CMD_POP_L  = 3'd2;
    localparam t_cmd CMD_POP_R  = 3'd3;
    localparam t_cmd CMD_PEEK_L = 3'd4;
    localparam t_cmd CMD_PEEK_R = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // input transfer: latch item, start memory read
        logic commit;   // execute item, update counts, load result register
    } t_dp_cmd;

endpackage
`default_nettype wire

@@ rtl/tsoa_ctrl.sv @@
// Controller: two-state sequencer and output valid for the two-stack unit.
`timescale 1ns / 1ps
`default_nettype none
module tsoa_ctrl
    import tsoa_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    output t_dp_cmd o_dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_comb begin
        out_free            = !r_out_valid || i_out_ready;
        o_in_ready          = (r_state == S_IDLE);
        o_dp_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
        o_dp_cmd.commit     = (r_state == S_EXEC) && out_free;
        n_state             = r_state;
        n_out_valid         = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/tsoa_datapath.sv @@
// Datapath: shared word store, stack counts and result register.
`timescale 1ns / 1ps
`default_nettype none
module tsoa_datapath
    import tsoa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_dp_cmd                  i_dp_cmd,
    input  wire  [CMD_W-1:0]         i_cmd,
    input  wire  signed [WORD_W-1:0] i_value,
    output logic signed [WORD_W-1:0] o_read_word,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_is_full,
    output logic                     o_left_is_empty,
    output logic                     o_right_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [CW-1:0]     r_left_cnt, n_left_cnt;
    logic [CW-1:0]     r_right_cnt, n_right_cnt;
    t_cmd              r_cmd;
    logic [WORD_W-1:0] r_value;
    logic [WORD_W-1:0] r_rd_data;

    logic [CW-1:0]     rd_ptr, wr_ptr;
    logic [CW:0]       cur_sum, nxt_sum;
    logic              full_now;
    logic              wr_en;
    logic [WORD_W-1:0] res_word;
    t_status           res_status;

    // Read address chosen from the counts at capture; counts are stable until commit.
    always_comb begin
        if (i_cmd[0]) begin
            rd_ptr = CAP_C - r_right_cnt;
        end else begin
            rd_ptr = r_left_cnt - ONE_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd     <= i_cmd;
            r_value   <= i_value;
            r_rd_data <= mem[rd_ptr[AW-1:0]];
        end
    end

    always_comb begin
        cur_sum     = {1'b0, r_left_cnt} + {1'b0, r_right_cnt};
        full_now    = (cur_sum >= {1'b0, CAP_C});
        n_left_cnt  = r_left_cnt;
        n_right_cnt = r_right_cnt;
        wr_en       = 1'b0;
        wr_ptr      = r_left_cnt;
        res_word    = '0;
        res_status  = ST_OK;
        case (r_cmd)
            CMD_PUSH_L: begin
                if (full_now) begin
                    res_status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    n_left_cnt = r_left_cnt + ONE_C;
                end
            end
            CMD_PUSH_R: begin
                wr_ptr = CAP_C - r_right_cnt - ONE_C;
                if (full_now) begin
                    res_status = ST_FULL;
                end else begin
                    wr_en       = 1'b1;
                    n_right_cnt = r_right_cnt + ONE_C;
                end
            end
            CMD_POP_L, CMD_PEEK_L: begin
                if (r_left_cnt == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_word = r_rd_data;
                    if (r_cmd == CMD_POP_L) begin
                        n_left_cnt = r_left_cnt - ONE_C;
                    end
                end
            end
            CMD_POP_R, CMD_PEEK_R: begin
                if (r_right_cnt == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_word = r_rd_data;
                    if (r_cmd == CMD_POP_R) begin
                        n_right_cnt = r_right_cnt - ONE_C;
                    end
                end
            end
            default: begin
            end
        endcase
        nxt_sum = {1'b0, n_left_cnt} + {1'b0, n_right_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit && wr_en) begin
            mem[wr_ptr[AW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
        end else if (i_dp_cmd.commit) begin
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit) begin
            o_read_word      <= res_word;
            o_status         <= res_status;
            o_is_full        <= (nxt_sum >= {1'b0, CAP_C});
            o_left_is_empty  <= (n_left_cnt == '0);
            o_right_is_empty <= (n_right_cnt == '0);
        end
    end

endmodule
`default_nettype wire

@@ rtl/two_stacks_one_array_unit.sv @@
// Top level: two stacks sharing one word store, with valid/ready channels.
//
// Usage
//   Input channel : i_in_valid / o_in_ready carry i_cmd and i_value. A command
//                   transfer happens on a rising edge with both high.
//   Output channel: o_out_valid / i_out_ready carry one result per command:
//                   o_read_word, o_status and the full / empty flags as they
//                   stand after that command.
//   Sequence      : the store read is registered at the input transfer edge;
//                   the execute state then loads the result register and
//                   raises o_out_valid once the result register is free.
//   Issue         : a command is taken only after the previous one executes;
//                   the store has a registered read port, and each command's
//                   read address depends on the counts left by the last one.
//   Stall         : the result register holds while i_out_ready is low; one
//                   further command may be taken and then waits in execute
//                   until the result register is free.
//   Reset         : i_rst_n (synchronous, active low) empties both stacks and
//                   clears the handshake state. Store contents are not
//                   cleared; no command can read an entry never pushed.
`timescale 1ns / 1ps
`default_nettype none
module two_stacks_one_array_unit
    import tsoa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [CMD_W-1:0]         i_cmd,
    input  wire  signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic signed [WORD_W-1:0] o_read_word,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_is_full,
    output logic                     o_left_is_empty,
    output logic                     o_right_is_empty
);

    t_dp_cmd dp_cmd;

    // Sequencer: capture on input transfer, commit once result register is free
    tsoa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (dp_cmd)
    );

    // Store, counts and result register
    tsoa_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .o_read_word      (o_read_word),
        .o_status         (o_status),
        .o_is_full        (o_is_full),
        .o_left_is_empty  (o_left_is_empty),
        .o_right_is_empty (o_right_is_empty)
    );

    // After a command transfer the input is closed while that command executes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a command is executing");

    // Only defined status codes reach the output.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_FULL ||
                         o_status == ST_EMPTY))
        else $error("undefined status code");

    // A full store cannot have both stacks empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_full) |-> !(o_left_is_empty && o_right_is_empty))
        else $error("full flag with both stacks empty");

    // A refused command (empty read or full push) returns a zero word.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_word == '0))
        else $error("refused command returned a nonzero word");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for two_stacks_one_array_unit: shadow-stack prediction, random traffic, stalls.
`timescale 1ns / 1ps
module tb;
    import tsoa_pkg::*;

    localparam int DEPTH       = DEF_CAPACITY;
    localparam int RANDOM_CMDS = 700;
    // Worst correct run is roughly 730 transfers, each with at most a long send gap and
    // a long stall; this limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 400000;

    // Codes 6 and 7 are unused by the block and must act as no-ops.
    localparam t_cmd CMD_NOP_6 = 3'd6;
    localparam t_cmd CMD_NOP_7 = 3'd7;

    typedef enum logic [1:0] {FILL_HEAVY, DRAIN_HEAVY, ANY_MIX} traffic_mix_t;

    // One predicted result, field for field as the output port carries it.
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        t_status             status;
        logic                full;
        logic                l_empty;
        logic                r_empty;
    } stack_reply_t;

    // DUT ports; every input is known from time zero.
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_cmd         = '0;
    logic signed [WORD_W-1:0] i_value       = '0;
    logic                     o_out_valid;
    logic                     i_out_ready   = 1'b0;
    logic signed [WORD_W-1:0] o_read_word;
    logic [STATUS_W-1:0]      o_status;
    logic                     o_is_full;
    logic                     o_left_is_empty;
    logic                     o_right_is_empty;

    // Shadow copy of the two stacks and their shared word store.
    logic [WORD_W-1:0] mirror_words [DEPTH];
    int unsigned       left_depth  = 0;
    int unsigned       right_depth = 0;

    stack_reply_t pending_replies [$];   // predictions waiting for their output transfer
    int unsigned  bad_results = 0;
    int unsigned  cycle_cnt   = 0;
    int unsigned  stall_left  = 0;
    bit           in_calm     = 1'b0;    // sender runs back to back while set
    bit           out_calm    = 1'b0;    // receiver starts no new stall while set

    two_stacks_one_array_unit #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_word     (o_read_word),
        .o_status        (o_status),
        .o_is_full       (o_is_full),
        .o_left_is_empty (o_left_is_empty),
        .o_right_is_empty(o_right_is_empty)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one command to the shadow stacks and returns what the block must answer.
    // Full means both stacks together hold DEPTH words; reads never touch an
    // entry that was not pushed, since counts start at zero after reset.
    function automatic stack_reply_t stack_cmd_effect(t_cmd cmd, logic [WORD_W-1:0] value);
        stack_reply_t r;
        r        = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_L: begin
                if (left_depth + right_depth >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_words[left_depth] = value;
                    left_depth++;
                end
            end
            CMD_PUSH_R: begin
                if (left_depth + right_depth >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    right_depth++;
                    mirror_words[DEPTH - right_depth] = value;
                end
            end
            CMD_POP_L, CMD_PEEK_L: begin
                if (left_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = mirror_words[left_depth - 1];
                    if (cmd == CMD_POP_L) left_depth--;
                end
            end
            CMD_POP_R, CMD_PEEK_R: begin
                if (right_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = mirror_words[DEPTH - right_depth];
                    if (cmd == CMD_POP_R) right_depth--;
                end
            end
            default: ;  // unused codes: nothing changes
        endcase
        r.full    = (left_depth + right_depth >= DEPTH);
        r.l_empty = (left_depth == 0);
        r.r_empty = (right_depth == 0);
        return r;
    endfunction

    // Idle length shared by both sides: mostly none, some short, a few long.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Push values lean toward the sign and all-ones corners.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        if (bad_results < 10) $display("%0t: %s", $realtime, what);
        bad_results++;
    endtask

    // Sends one command; returns at the edge where the input transfer happens,
    // with the prediction already queued. Valid is only lowered for a real gap.
    task automatic issue_cmd(input t_cmd cmd, input logic [WORD_W-1:0] value);
        int unsigned gap;
        gap = in_calm ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_replies.push_back(stack_cmd_effect(cmd, value));
    endtask

    // Holds the sender until every predicted result has been seen.
    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Reads on both empty sides, then the two unused codes.
    task automatic test_empty_side();
        issue_cmd(CMD_POP_L,  32'hDEAD_BEEF);
        issue_cmd(CMD_POP_R,  32'h1234_5678);
        issue_cmd(CMD_PEEK_L, '0);
        issue_cmd(CMD_PEEK_R, '1);
        issue_cmd(CMD_NOP_6,  32'h8000_0000);
        issue_cmd(CMD_NOP_7,  32'h7FFF_FFFF);
    endtask

    // Fills the store from both ends, corner words first, pushes into the full
    // store on each side, then pops one from each side to clear full.
    task automatic test_full_store();
        logic [WORD_W-1:0] corner [4];
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        for (int k = 0; k < DEPTH; k++) begin
            issue_cmd(k[0] ? CMD_PUSH_R : CMD_PUSH_L, (k < 8) ? corner[k % 4] : $urandom);
        end
        issue_cmd(CMD_PUSH_L, 32'h5555_5555);
        issue_cmd(CMD_PUSH_R, 32'hAAAA_AAAA);
        issue_cmd(CMD_POP_L, '0);
        issue_cmd(CMD_POP_R, '0);
    endtask

    // Runs of fill-heavy, drain-heavy and mixed traffic so both stacks
    // repeatedly reach full and empty. Idling is switched off for some runs,
    // and half-way the sender waits for the pipe to drain.
    task automatic test_random_traffic();
        int unsigned  sent;
        int unsigned  run_len;
        int unsigned  roll;
        bit           side;
        bit           drained;
        traffic_mix_t mix;
        t_cmd         cmd;
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_CMDS) begin
            mix      = traffic_mix_t'($urandom_range(0, 2));
            run_len  = $urandom_range(8, 40);
            in_calm  = ($urandom_range(0, 4) == 0);
            out_calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < run_len; k++) begin
                roll = $urandom_range(0, 99);
                side = $urandom_range(0, 1);
                case (mix)
                    FILL_HEAVY: begin
                        if (roll < 75)      cmd = side ? CMD_PUSH_R : CMD_PUSH_L;
                        else if (roll < 90) cmd = side ? CMD_POP_R  : CMD_POP_L;
                        else                cmd = side ? CMD_PEEK_R : CMD_PEEK_L;
                    end
                    DRAIN_HEAVY: begin
                        if (roll < 75)      cmd = side ? CMD_POP_R  : CMD_POP_L;
                        else if (roll < 85) cmd = side ? CMD_PUSH_R : CMD_PUSH_L;
                        else                cmd = side ? CMD_PEEK_R : CMD_PEEK_L;
                    end
                    default: begin
                        if (roll < 4) cmd = side ? CMD_NOP_7 : CMD_NOP_6;
                        else          cmd = t_cmd'($urandom_range(CMD_PUSH_L, CMD_PEEK_R));
                    end
                endcase
                issue_cmd(cmd, pick_word());
                sent++;
            end
            if (!drained && sent >= RANDOM_CMDS / 2) begin
                wait_for_replies();
                drained = 1'b1;
            end
        end
        in_calm  = 1'b0;
        out_calm = 1'b0;
    endtask

    // Receiver: random stall runs on the output channel.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!out_calm && $urandom_range(0, 99) < 30) begin
            stall_left  <= idle_len();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Checker: each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        stack_reply_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                note_mismatch($sformatf("unexpected result word=%h status=%0d",
                                        o_read_word, o_status));
            end else begin
                want = pending_replies.pop_front();
                if (o_read_word !== want.word || o_status !== want.status ||
                    o_is_full !== want.full || o_left_is_empty !== want.l_empty ||
                    o_right_is_empty !== want.r_empty) begin
                    note_mismatch($sformatf(
                        "exp word=%h st=%0d full=%b le=%b re=%b, got word=%h st=%0d full=%b le=%b re=%b",
                        want.word, want.status, want.full, want.l_empty, want.r_empty,
                        o_read_word, o_status, o_is_full, o_left_is_empty, o_right_is_empty));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("two_stacks_one_array_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_side();
        test_full_store();
        test_random_traffic();
        wait_for_replies();
        repeat (8) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("two_stacks_one_array_unit: match");
        end else begin
            $display("two_stacks_one_array_unit: mismatch");
        end
        $finish;
    end

endmodule
